### rtl/core/rfsa_pkg.sv
`default_nettype none

package rfsa_pkg;

  // Fixed field widths of the request, result, row-table and configuration words.
  localparam int unsigned WANT_W     = 4;
  localparam int unsigned FREE_W     = 4;
  localparam int unsigned SEAT_W     = 9;
  localparam int unsigned ROWS_CFG_W = 6;

  localparam logic [ROWS_CFG_W-1:0] ROWS_IN_USE_RESET = 6'd32;

  localparam int unsigned DEF_ROWS          = 32;
  localparam int unsigned DEF_SEATS_PER_ROW = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_REFUSE,
    ST_RREQ,
    ST_RDATA,
    ST_EMIT,
    ST_WRITE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic pick;
    logic load_row;
    logic next_row;
    logic emit;
    logic write_row;
    logic refuse;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic invalid;
    logic take_zero;
    logic out_free;
    logic last_take;
    logic req_done;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/rfsa_req_if.sv
`default_nettype none

interface rfsa_req_if;
  logic                        valid;
  logic                        ready;
  logic [rfsa_pkg::WANT_W-1:0] seats_wanted;

  modport source (output valid, output seats_wanted, input ready);
  modport sink (input valid, input seats_wanted, output ready);
endinterface

`default_nettype wire

### rtl/core/rfsa_seat_if.sv
`default_nettype none

interface rfsa_seat_if;
  logic                        valid;
  logic                        ready;
  logic [rfsa_pkg::SEAT_W-1:0] seat_number;
  logic                        last_of_request;
  logic                        refused;

  modport source (output valid, output seat_number, output last_of_request,
                  output refused, input ready);
  modport sink (input valid, input seat_number, input last_of_request,
                input refused, output ready);
endinterface

`default_nettype wire

### rtl/core/rfsa_ctrl.sv
`default_nettype none

module rfsa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rfsa_pkg::sts_t sts,
  output rfsa_pkg::cmd_t     cmd
);

  rfsa_pkg::state_t state;
  rfsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      rfsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = rfsa_pkg::ST_SCAN;
        end
      end
      rfsa_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = rfsa_pkg::ST_DECIDE;
        end
      end
      rfsa_pkg::ST_DECIDE: begin
        if (sts.invalid) begin
          state_next = rfsa_pkg::ST_REFUSE;
        end else begin
          cmd.pick   = 1'b1;
          state_next = rfsa_pkg::ST_RREQ;
        end
      end
      rfsa_pkg::ST_REFUSE: begin
        if (sts.out_free) begin
          cmd.refuse = 1'b1;
          state_next = rfsa_pkg::ST_IDLE;
        end
      end
      rfsa_pkg::ST_RREQ: begin
        state_next = rfsa_pkg::ST_RDATA;
      end
      rfsa_pkg::ST_RDATA: begin
        // An empty row is passed over while scattering.
        if (sts.take_zero) begin
          cmd.next_row = 1'b1;
          state_next   = rfsa_pkg::ST_RREQ;
        end else begin
          cmd.load_row = 1'b1;
          state_next   = rfsa_pkg::ST_EMIT;
        end
      end
      rfsa_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_take) begin
            state_next = rfsa_pkg::ST_WRITE;
          end
        end
      end
      rfsa_pkg::ST_WRITE: begin
        cmd.write_row = 1'b1;
        if (sts.req_done) begin
          state_next = rfsa_pkg::ST_IDLE;
        end else begin
          cmd.next_row = 1'b1;
          state_next   = rfsa_pkg::ST_RREQ;
        end
      end
      default: begin
        state_next = rfsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/rfsa_datapath.sv
`default_nettype none

module rfsa_datapath #(
  parameter int unsigned ROWS          = rfsa_pkg::DEF_ROWS,
  parameter int unsigned SEATS_PER_ROW = rfsa_pkg::DEF_SEATS_PER_ROW
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [rfsa_pkg::ROWS_CFG_W-1:0]    cfg_wdata,
  input  wire logic [rfsa_pkg::WANT_W-1:0]        seats_wanted,
  input  wire rfsa_pkg::cmd_t                     cmd,
  output rfsa_pkg::sts_t                          sts,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [rfsa_pkg::SEAT_W-1:0]             out_seat,
  output logic                                    out_last,
  output logic                                    out_refused
);

  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned RCW  = $clog2(ROWS + 1);
  localparam int unsigned TW   = $clog2(ROWS * SEATS_PER_ROW + 1);
  localparam int unsigned CW   = TW + rfsa_pkg::WANT_W;
  localparam int unsigned BW   = $clog2(ROWS * SEATS_PER_ROW + 2);
  localparam int unsigned FW   = rfsa_pkg::FREE_W;
  localparam int unsigned WW   = rfsa_pkg::WANT_W;
  localparam logic [FW-1:0] FULL_ROW = FW'(SEATS_PER_ROW);

  logic [rfsa_pkg::ROWS_CFG_W-1:0] rows_in_use;
  logic [RCW-1:0]                  nrows;

  // Row table: free count per row, one read and one write port.
  logic [FW-1:0]   free_mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [RW-1:0]   rd_addr;
  logic [FW-1:0]   rd_mem;
  logic            rd_vld;
  logic [FW-1:0]   rd_free;

  logic [WW-1:0]   want_q;
  logic [RCW-1:0]  scan_idx;
  logic            pend;
  logic [RW-1:0]   pend_row;
  logic [TW-1:0]   total;
  logic            found;
  logic [RW-1:0]   fit_row;

  logic [RW-1:0]             cur_row;
  logic [FW-1:0]             cur_free;
  logic [WW-1:0]             take_left;
  logic [WW-1:0]             rem;
  logic [rfsa_pkg::SEAT_W-1:0] seat_ptr;

  logic [WW-1:0] take;
  logic [BW-1:0] row_end;
  logic [BW-1:0] base;

  always_comb begin
    if (rows_in_use == '0) begin
      nrows = RCW'(1);
    end else if (7'(rows_in_use) > 7'(ROWS)) begin
      nrows = RCW'(ROWS);
    end else begin
      nrows = RCW'(rows_in_use);
    end
  end

  assign rd_addr = cmd.scan ? scan_idx[RW-1:0] : cur_row;
  assign rd_free = rd_vld ? rd_mem : FULL_ROW;

  // The row gives up what it has, at most what the request still needs.
  assign take    = (WW'(rd_free) < rem) ? WW'(rd_free) : rem;
  assign row_end = BW'((32'(cur_row) + 32'd1) * SEATS_PER_ROW);
  assign base    = row_end + BW'(1) - BW'(rd_free);

  always_comb begin
    sts.scan_done = !pend && (scan_idx == nrows);
    sts.invalid   = (want_q == '0) || (want_q > WW'(SEATS_PER_ROW)) ||
                    (CW'(want_q) > CW'(total));
    sts.take_zero = (take == '0);
    sts.out_free  = !out_valid || out_ready;
    sts.last_take = (take_left == WW'(1));
    sts.req_done  = (rem == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.write_row) begin
      free_mem[cur_row] <= cur_free;
    end
    rd_mem <= free_mem[rd_addr];
    rd_vld <= row_valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= rfsa_pkg::ROWS_IN_USE_RESET;
      row_valid   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        rows_in_use <= cfg_wdata;
      end
      if (cmd.write_row) begin
        row_valid[cur_row] <= 1'b1;
      end
      if (cmd.emit || cmd.refuse) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Search pass: sums the free counts and finds the first row that fits.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      want_q   <= seats_wanted;
      scan_idx <= '0;
      pend     <= 1'b0;
      total    <= '0;
      found    <= 1'b0;
    end else if (cmd.scan) begin
      if (scan_idx < nrows) begin
        scan_idx <= scan_idx + RCW'(1);
        pend     <= 1'b1;
        pend_row <= scan_idx[RW-1:0];
      end else begin
        pend <= 1'b0;
      end
      if (pend) begin
        total <= total + TW'(rd_free);
        if (!found && (WW'(rd_free) >= want_q)) begin
          found   <= 1'b1;
          fit_row <= pend_row;
        end
      end
    end
  end

  // Placement: walks rows and hands out seats one word at a time.
  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      cur_row <= found ? fit_row : '0;
      rem     <= want_q;
    end
    if (cmd.next_row) begin
      cur_row <= cur_row + RW'(1);
    end
    if (cmd.load_row) begin
      cur_free  <= rd_free;
      take_left <= take;
      seat_ptr  <= rfsa_pkg::SEAT_W'(base);
    end
    if (cmd.emit) begin
      out_seat    <= seat_ptr;
      out_last    <= (rem == WW'(1));
      out_refused <= 1'b0;
      seat_ptr    <= seat_ptr + rfsa_pkg::SEAT_W'(1);
      take_left   <= take_left - WW'(1);
      rem         <= rem - WW'(1);
      cur_free    <= cur_free - FW'(1);
    end
    if (cmd.refuse) begin
      out_seat    <= '0;
      out_last    <= 1'b1;
      out_refused <= 1'b1;
    end
  end

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (take_left != '0) && (cur_free != '0) && (rem != '0))
    else $error("seat emitted with nothing left to take");

  a_refusal_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_refused |-> out_last && (out_seat == '0))
    else $error("refusal word malformed");

  a_writeback_after_row: assert property (@(posedge clk) disable iff (rst)
    cmd.write_row |-> (take_left == '0))
    else $error("row written back before its seats were emitted");

  a_last_ends_row: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && (rem == WW'(1)) |-> (take_left == WW'(1)))
    else $error("request ended in the middle of a row take");

endmodule

`default_nettype wire

### rtl/core/row_first_fit_seat_allocator.sv
`default_nettype none

// Row first-fit seat allocator. A request for k seats goes to the lowest row
// in use with k free seats, else it is spread over the lowest free seats in
// ascending order; one word per seat comes out, the final one marked, and an
// invalid or oversized request yields a single refused word with seat 0.
// Every request first reads the free-count table one row per cycle over the
// rows in use; then, for each row visited, it reads the free count and, where
// the row gives seats, emits one word per seat while the output can accept
// it and writes the row back. One request is worked at a time; a finished
// word may wait at the output while the next request is taken. rows_in_use
// may only be written while idle.
module row_first_fit_seat_allocator #(
  parameter int unsigned ROWS          = rfsa_pkg::DEF_ROWS,
  parameter int unsigned SEATS_PER_ROW = rfsa_pkg::DEF_SEATS_PER_ROW
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [rfsa_pkg::ROWS_CFG_W-1:0] cfg_wdata,
  rfsa_req_if.sink                             req,
  rfsa_seat_if.source                          seat
);

  rfsa_pkg::cmd_t cmd;
  rfsa_pkg::sts_t sts;

  rfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rfsa_datapath #(
    .ROWS          (ROWS),
    .SEATS_PER_ROW (SEATS_PER_ROW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .seats_wanted (req.seats_wanted),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (seat.valid),
    .out_ready    (seat.ready),
    .out_seat     (seat.seat_number),
    .out_last     (seat.last_of_request),
    .out_refused  (seat.refused)
  );

endmodule

`default_nettype wire
